FILE: design/tdwf_pkg.sv
// Package with shared types and constants for the trie dictionary word-end finder.
`timescale 1ns / 1ps
package tdwf_pkg;

   // Codes carried in the mode field of an input word.
   localparam logic [1:0] MODE_WRITE  = 2'd0;
   localparam logic [1:0] MODE_TEXT   = 2'd1;
   localparam logic [1:0] MODE_CLEAR  = 2'd2;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   // Record layout.
   localparam int unsigned ADDR_BITS  = 33;
   localparam int unsigned NODE_BITS  = 23;
   localparam int unsigned COUNT_BITS = 31;
   localparam int unsigned TABLE_BIT  = 31;
   localparam int unsigned END_BIT    = 23;
   localparam int unsigned CHAR_LO    = 24;

   // Request from the sequencer to the dictionary memory.
   typedef struct packed {
      logic                 wr_en;
      logic [15:0]          wr_addr;
      logic [31:0]          wr_data;
      logic [ADDR_BITS-1:0] rd_addr;
   } dict_req_type;

endpackage

FILE: design/tdwf_dict_mem.sv
// Dictionary word memory with a registered read port and out-of-range reads as zero.
`timescale 1ns / 1ps
module tdwf_dict_mem #(
   parameter int unsigned DICT_WORDS = 65536
) (
   input  logic                  clock,
   input  tdwf_pkg::dict_req_type req,
   output logic [31:0]           rd_data
);
   localparam int unsigned AW = $clog2(DICT_WORDS);

   logic [31:0] mem [DICT_WORDS];
   logic [31:0] rd_raw_ff;
   logic        rd_oor_ff;
   logic        wr_ok;
   logic        rd_oor;

   // Range checks against the memory depth.
   assign wr_ok  = ({{(tdwf_pkg::ADDR_BITS-16){1'b0}}, req.wr_addr}
                    < tdwf_pkg::ADDR_BITS'(DICT_WORDS));
   assign rd_oor = (req.rd_addr >= tdwf_pkg::ADDR_BITS'(DICT_WORDS));

   // Write port.
   always_ff @(posedge clock) begin
      if (req.wr_en && wr_ok) begin
         mem[AW'(req.wr_addr)] <= req.wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_raw_ff <= mem[req.rd_addr[AW-1:0]];
      rd_oor_ff <= rd_oor;
   end

   assign rd_data = rd_oor_ff ? 32'd0 : rd_raw_ff;

endmodule

FILE: design/trie_dictionary_word_end_finder.sv
// Top level of the trie dictionary word-end finder: sequencer, cursor store and output stage.
`timescale 1ns / 1ps
// A text byte keeps req_tready low while the sequencer walks each live cursor: a table
// node takes a header read and a record read, a list node a header read and a binary
// search of up to nine probes for 256 entries (plus a final range check when it misses),
// a dead node no read, and each word result goes to the output register; a result that
// waits on the receiver holds the sequencer. All dictionary reads go through the single
// registered memory read port, which sets the rate. The block takes no word while a byte
// is in work; the result register lets the next word be taken while the end marker still waits.
module trie_dictionary_word_end_finder #(
   parameter int unsigned DICT_WORDS  = 65536,
   parameter int unsigned MAX_CURSORS = 32,
   parameter int unsigned POS_BITS    = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // dict_addr[15:0], dict_word[47:16], text_byte[55:48]
   input  logic [55:0]         req_tdata,
   // mode[1:0]
   input  logic [1:0]          req_tuser,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // word_start, then end_pos, POS_BITS each, zero padded to bytes
   output logic [((2*POS_BITS+7)/8)*8-1:0] rsp_tdata,
   // word_found[0], overflow[1]
   output logic [1:0]          rsp_tuser,
   output logic                rsp_tlast
);
   localparam int unsigned CW = $clog2(MAX_CURSORS + 1);
   localparam int unsigned IW = (MAX_CURSORS > 1) ? $clog2(MAX_CURSORS) : 1;
   localparam int unsigned OW = ((2*POS_BITS+7)/8)*8;
   localparam int unsigned AB = tdwf_pkg::ADDR_BITS;
   localparam int unsigned NB = tdwf_pkg::NODE_BITS;
   localparam int unsigned KB = tdwf_pkg::COUNT_BITS;

   typedef enum logic [2:0] {
      S_IDLE, S_NEXT, S_HDR, S_LST, S_LCMP, S_REC, S_EMIT, S_END
   } state_type;

   state_type         state_ff;
   logic [CW-1:0]     count_ff, i_ff, keep_ff;
   logic [POS_BITS-1:0] pos_ff, hit_start_ff;
   logic [7:0]        ch_ff;
   logic              ovf_ff;
   logic [NB-1:0]     base_ff;
   logic [KB-1:0]     lo_ff, hi_ff, mid_ff;
   logic [NB-1:0]     node_ff  [MAX_CURSORS];
   logic [POS_BITS-1:0] start_ff [MAX_CURSORS];
   logic              rsp_valid_ff;
   logic [POS_BITS-1:0] rsp_start_ff, rsp_pos_ff;
   logic              rsp_found_ff, rsp_ovf_ff, rsp_last_ff;

   tdwf_pkg::dict_req_type mem_req;
   logic [31:0]       rd_data;
   logic [NB-1:0]     cur_node;
   logic [POS_BITS-1:0] cur_start;
   logic [KB:0]       mid_sum;
   logic [KB-1:0]     mid_in;
   logic              out_free;
   logic              rsp_load;
   logic              accept;
   logic [7:0]        tch;

   tdwf_dict_mem #(.DICT_WORDS(DICT_WORDS)) u_mem (
      .clock  (clock),
      .req    (mem_req),
      .rd_data(rd_data)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_load   = out_free && ((state_ff == S_EMIT) || (state_ff == S_END));
   assign cur_node   = node_ff[i_ff[IW-1:0]];
   assign cur_start  = start_ff[i_ff[IW-1:0]];
   assign mid_sum    = {1'b0, lo_ff} + {1'b0, hi_ff} - (KB+1)'(1);
   assign mid_in     = mid_sum[KB:1];
   assign tch        = rd_data[31:tdwf_pkg::CHAR_LO];

   // Memory request: one read address per cycle from the sequencer.
   always_comb begin
      mem_req.wr_en   = accept && (req_tuser == tdwf_pkg::MODE_WRITE);
      mem_req.wr_addr = req_tdata[15:0];
      mem_req.wr_data = req_tdata[47:16];
      case (state_ff)
         S_NEXT:  mem_req.rd_addr = AB'(cur_node) - AB'(1);
         S_HDR:   mem_req.rd_addr = AB'(base_ff) + AB'(1) + AB'(ch_ff);
         S_LST:   mem_req.rd_addr = AB'(base_ff) + AB'(1) + AB'(mid_in);
         default: mem_req.rd_addr = AB'(base_ff);
      endcase
   end

   // Sequencer, cursor store and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         i_ff         <= '0;
         keep_ff      <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // A taken result frees the register unless a new one is loaded now.
         if (rsp_valid_ff && rsp_tready && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  if (req_tuser == tdwf_pkg::MODE_CLEAR) begin
                     count_ff <= '0;
                     pos_ff   <= '0;
                  end else if (req_tuser == tdwf_pkg::MODE_TEXT) begin
                     ch_ff   <= req_tdata[55:48];
                     i_ff    <= '0;
                     keep_ff <= '0;
                     if (count_ff < CW'(MAX_CURSORS)) begin
                        node_ff[count_ff[IW-1:0]]  <= NB'(1);
                        start_ff[count_ff[IW-1:0]] <= pos_ff;
                        count_ff <= count_ff + CW'(1);
                        ovf_ff   <= 1'b0;
                     end else begin
                        ovf_ff <= 1'b1;
                     end
                     state_ff <= S_NEXT;
                  end
               end
            end
            S_NEXT: begin
               if (i_ff == count_ff) begin
                  state_ff <= S_END;
               end else if (cur_node == '0) begin
                  i_ff <= i_ff + CW'(1);
               end else begin
                  base_ff  <= cur_node - NB'(1);
                  state_ff <= S_HDR;
               end
            end
            S_HDR: begin
               if (rd_data[tdwf_pkg::TABLE_BIT]) begin
                  state_ff <= S_REC;
               end else begin
                  lo_ff    <= '0;
                  hi_ff    <= rd_data[KB-1:0];
                  state_ff <= S_LST;
               end
            end
            S_LST: begin
               // Empty range means the character is not in the list.
               if (lo_ff >= hi_ff) begin
                  i_ff     <= i_ff + CW'(1);
                  state_ff <= S_NEXT;
               end else begin
                  mid_ff   <= mid_in;
                  state_ff <= S_LCMP;
               end
            end
            S_LCMP, S_REC: begin
               if ((state_ff == S_LCMP) && (ch_ff < tch)) begin
                  hi_ff    <= mid_ff;
                  state_ff <= S_LST;
               end else if ((state_ff == S_LCMP) && (ch_ff > tch)) begin
                  lo_ff    <= mid_ff + KB'(1);
                  state_ff <= S_LST;
               end else if ((state_ff == S_REC) && (tch == 8'd0)) begin
                  i_ff     <= i_ff + CW'(1);
                  state_ff <= S_NEXT;
               end else begin
                  // Survivor moves down to the next kept slot.
                  node_ff[keep_ff[IW-1:0]]  <= rd_data[NB-1:0];
                  start_ff[keep_ff[IW-1:0]] <= cur_start;
                  keep_ff      <= keep_ff + CW'(1);
                  hit_start_ff <= cur_start;
                  if (rd_data[tdwf_pkg::END_BIT]) begin
                     state_ff <= S_EMIT;
                  end else begin
                     i_ff     <= i_ff + CW'(1);
                     state_ff <= S_NEXT;
                  end
               end
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_start_ff <= hit_start_ff;
                  rsp_found_ff <= 1'b1;
                  rsp_pos_ff   <= pos_ff;
                  rsp_last_ff  <= 1'b0;
                  rsp_ovf_ff   <= ovf_ff;
                  i_ff         <= i_ff + CW'(1);
                  state_ff     <= S_NEXT;
               end
            end
            S_END: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_start_ff <= '0;
                  rsp_found_ff <= 1'b0;
                  rsp_pos_ff   <= pos_ff;
                  rsp_last_ff  <= 1'b1;
                  rsp_ovf_ff   <= ovf_ff;
                  count_ff     <= keep_ff;
                  pos_ff       <= pos_ff + POS_BITS'(1);
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = OW'({rsp_pos_ff, rsp_start_ff});
   assign rsp_tuser  = {rsp_ovf_ff, rsp_found_ff};
   assign rsp_tlast  = rsp_last_ff;

   // Compaction never overtakes the scan; while a word result waits, the kept slot of the
   // current cursor is already counted.
   a_keep_le_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_EMIT) |-> (keep_ff <= i_ff))
      else $error("kept cursor index ahead of scan index");

   // The cursor store never holds more than its depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_CURSORS)) else $error("cursor count above store depth");

   // A probe is only issued on a non-empty search range.
   a_probe_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LCMP) |-> (mid_ff < hi_ff) && (mid_ff >= lo_ff))
      else $error("binary search probe outside its range");

   // A result is only loaded while the output register is free.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> $stable(rsp_pos_ff) && $stable(rsp_last_ff))
      else $error("waiting result overwritten");

endmodule
